// ===== rtl/core/normalized_cross_product_core_defines.svh =====
// Assertion helpers used by the core top level.
`ifndef NORMALIZED_CROSS_PRODUCT_CORE_DEFINES_SVH
`define NORMALIZED_CROSS_PRODUCT_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define NCP_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define NCP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ncp_pkg.sv =====
`timescale 1ns / 1ps
package ncp_pkg;

  localparam int CW  = 16;       // input component width, Q8.8
  localparam int OFB = 14;       // output fraction bits
  localparam int OW  = OFB + 2;  // output component width
  localparam int PW  = 2 * CW;   // product width
  localparam int MW  = 2 * CW;   // cross component magnitude width
  localparam int SQW = 4 * CW;   // squared length width
  localparam int RW  = 2 * CW;   // root width

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bz;
  } req_t;

  typedef struct packed {
    logic signed [OW-1:0] ux;
    logic signed [OW-1:0] uy;
    logic signed [OW-1:0] uz;
    logic                 degenerate;
  } rsp_t;

  // One slot of the square-root chain.
  typedef struct packed {
    logic                 valid;
    logic [SQW-1:0]       rad;
    logic [RW+1:0]        rem;
    logic [RW-1:0]        root;
    logic [2:0]           neg;
    logic [2:0][MW-1:0]   mag;
  } sqrt_t;

  // One slot of the divider chain.
  typedef struct packed {
    logic                 valid;
    logic                 deg;
    logic [RW-1:0]        len;
    logic [2:0][RW:0]     r;
    logic [2:0][OFB:0]    q;
    logic [2:0]           neg;
  } div_t;

endpackage

// ===== rtl/core/ncp_front.sv =====
`timescale 1ns / 1ps
module ncp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid,
  input  ncp_pkg::req_t req,
  output ncp_pkg::sqrt_t head
);
  import ncp_pkg::*;

  logic                 va, vb, vc;
  logic signed [PW-1:0] p [6];
  logic [2:0]           neg_b, neg_c;
  logic [2:0][MW-1:0]   mag_b, mag_c;
  logic [SQW-1:0]       sq [3];
  logic signed [PW:0]   c [3];
  logic [2:0]           neg_w;
  logic [2:0][MW-1:0]   mag_w;

  // Form the cross differences and their magnitudes.
  always_comb begin
    c[0] = {p[0][PW-1], p[0]} - {p[1][PW-1], p[1]};
    c[1] = {p[2][PW-1], p[2]} - {p[3][PW-1], p[3]};
    c[2] = {p[4][PW-1], p[4]} - {p[5][PW-1], p[5]};
    for (int i = 0; i < 3; i++) begin
      neg_w[i] = c[i][PW];
      mag_w[i] = c[i][PW] ? MW'(-c[i]) : MW'(c[i]);
    end
  end

  // Advance valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      head.valid <= 1'b0;
    end else if (en) begin
      va <= valid;
      vb <= va;
      vc <= vb;
      head.valid <= vc;
    end
  end

  // Products, magnitudes, squares, sum.
  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= req.ay * req.bz;
      p[1] <= req.az * req.by;
      p[2] <= req.az * req.bx;
      p[3] <= req.ax * req.bz;
      p[4] <= req.ax * req.by;
      p[5] <= req.ay * req.bx;
      neg_b <= neg_w;
      mag_b <= mag_w;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= mag_b[i] * mag_b[i];
      end
      neg_c <= neg_b;
      mag_c <= mag_b;
      head.rad  <= sq[0] + sq[1] + sq[2];
      head.rem  <= '0;
      head.root <= '0;
      head.neg  <= neg_c;
      head.mag  <= mag_c;
    end
  end

endmodule

// ===== rtl/core/ncp_sqrt_cell.sv =====
`timescale 1ns / 1ps
module ncp_sqrt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  ncp_pkg::sqrt_t prev,
  output ncp_pkg::sqrt_t next
);
  import ncp_pkg::*;

  logic [RW+3:0] rem_w;
  logic [RW+3:0] trial;
  logic          ge;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    rem_w = {prev.rem, prev.rad[SQW-1 -: 2]};
    trial = {2'b00, prev.root, 2'b01};
    ge    = rem_w >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else if (en) begin
      next.valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      next.rad  <= {prev.rad[SQW-3:0], 2'b00};
      next.rem  <= ge ? (RW+2)'(rem_w - trial) : (RW+2)'(rem_w);
      next.root <= {prev.root[RW-2:0], ge};
      next.neg  <= prev.neg;
      next.mag  <= prev.mag;
    end
  end

endmodule

// ===== rtl/core/ncp_div_cell.sv =====
`timescale 1ns / 1ps
module ncp_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  ncp_pkg::div_t prev,
  output ncp_pkg::div_t next
);
  import ncp_pkg::*;

  logic [RW+1:0] rs [3];
  logic [2:0]    ge;

  // Shift each partial remainder and compare with the length.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs[i] = {prev.r[i], 1'b0};
      ge[i] = rs[i] >= {2'b00, prev.len};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else if (en) begin
      next.valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        next.r[i] <= ge[i] ? (RW+1)'(rs[i] - {2'b00, prev.len}) : (RW+1)'(rs[i]);
        next.q[i] <= {prev.q[i][OFB-1:0], ge[i]};
      end
      next.len <= prev.len;
      next.deg <= prev.deg;
      next.neg <= prev.neg;
    end
  end

endmodule

// ===== rtl/core/normalized_cross_product_core.sv =====
`timescale 1ns / 1ps
// Unit normal of two 3D vectors.
// Request channel: src_valid / src_stall / src_data carries two vectors of
// signed Q8.8 components. Result channel: dst_valid / dst_stall / dst_data
// carries the signed Q1.14 unit cross product and a degenerate flag, which
// is set (with zero components) when the cross product is zero.
// A request is taken at an edge with valid high and stall low.
// Pipeline: front registers for products, magnitudes, squares and sum,
// 32 square-root cells (one root bit each), one divider setup stage,
// 14 divider cells (one quotient bit each) and the output register.
// Throughput: one request per cycle when not stalled; every stage advances together.
// When the receiver stalls a held result, the whole chain freezes and
// src_stall rises in the same cycle; nothing is dropped.
// Reset clears every valid bit; payload registers are left as they are.
module normalized_cross_product_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          src_valid,
  output logic          src_stall,
  input  ncp_pkg::req_t src_data,
  output logic          dst_valid,
  input  logic          dst_stall,
  output ncp_pkg::rsp_t dst_data
);
  import ncp_pkg::*;

  logic  en;
  sqrt_t sq_chain [RW+1];
  div_t  dv_chain [OFB+1];
  logic [2:0]       ge0;
  logic [OW-1:0]    res [3];

  // Advance the chain unless a held result is stalled.
  assign en        = !(dst_valid && dst_stall);
  assign src_stall = !en;

  ncp_front u_front (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .valid(src_valid),
    .req  (src_data),
    .head (sq_chain[0])
  );

  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    ncp_sqrt_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .prev(sq_chain[g]),
      .next(sq_chain[g+1])
    );
  end

  // Set up division: leading quotient bit against the full length.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ge0[i] = sq_chain[RW].mag[i] >= sq_chain[RW].root;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_chain[0].valid <= 1'b0;
    end else if (en) begin
      dv_chain[0].valid <= sq_chain[RW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_chain[0].r[i] <= ge0[i]
            ? {1'b0, sq_chain[RW].mag[i] - sq_chain[RW].root}
            : {1'b0, sq_chain[RW].mag[i]};
        dv_chain[0].q[i] <= {{OFB{1'b0}}, ge0[i]};
      end
      dv_chain[0].len <= sq_chain[RW].root;
      dv_chain[0].deg <= sq_chain[RW].root == '0;
      dv_chain[0].neg <= sq_chain[RW].neg;
    end
  end

  for (genvar g = 0; g < OFB; g++) begin : g_div
    ncp_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .prev(dv_chain[g]),
      .next(dv_chain[g+1])
    );
  end

  // Apply signs; zero everything on a degenerate request.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res[i] = dv_chain[OFB].neg[i] ? OW'(-{1'b0, dv_chain[OFB].q[i]})
                                    : OW'({1'b0, dv_chain[OFB].q[i]});
      if (dv_chain[OFB].deg) begin
        res[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (en) begin
      dst_valid <= dv_chain[OFB].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dst_data.ux         <= res[0];
      dst_data.uy         <= res[1];
      dst_data.uz         <= res[2];
      dst_data.degenerate <= dv_chain[OFB].deg;
    end
  end

`include "normalized_cross_product_core_defines.svh"

  `NCP_ASSERT_NOW(a_deg_zero, dst_valid && dst_data.degenerate, dst_data.ux == '0 && dst_data.uy == '0 && dst_data.uz == '0, "degenerate result has nonzero components")
  `NCP_ASSERT_NOW(a_len_bound, dv_chain[OFB].valid && !dv_chain[OFB].deg, dv_chain[OFB].q[0] <= (OFB+1)'(1 << OFB) && dv_chain[OFB].q[1] <= (OFB+1)'(1 << OFB) && dv_chain[OFB].q[2] <= (OFB+1)'(1 << OFB), "quotient above unit range")
  `NCP_ASSERT_NEXT(a_freeze, src_stall, $stable(dv_chain[0].valid) && $stable(sq_chain[0].valid), "chain moved while stalled")

endmodule

// ===== dv/tb_normalized_cross_product_core.sv =====
`timescale 1ns / 1ps
module tb_normalized_cross_product_core;
  import ncp_pkg::*;

  localparam int LATENCY     = 52;
  localparam int NUM_RANDOM  = 2000;
  localparam int CYCLE_LIMIT = 400000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  src_valid = 1'b0;
  logic  src_stall;
  req_t  src_data = '0;
  logic  dst_valid;
  logic  dst_stall = 1'b1;
  rsp_t  dst_data;

  int mismatch_count = 0;
  int cycle_count = 0;
  bit stim_done = 1'b0;

  always #5 clk = ~clk;

  normalized_cross_product_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
  );

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // Fixed-point unit normal predictor
  function automatic rsp_t unit_normal(input req_t v);
    rsp_t          r;
    longint        c [3];
    logic [127:0]  sq;
    logic [127:0]  t2;
    logic [63:0]   len;
    logic [63:0]   t;
    logic [63:0]   mag;
    logic [63:0]   rem;
    logic [63:0]   q;
    logic [OW-1:0] o [3];
    c[0] = longint'(v.ay) * v.bz - longint'(v.az) * v.by;
    c[1] = longint'(v.az) * v.bx - longint'(v.ax) * v.bz;
    c[2] = longint'(v.ax) * v.by - longint'(v.ay) * v.bx;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      mag = c[i] < 0 ? -c[i] : c[i];
      sq += 128'(mag) * 128'(mag);
    end
    len = 0;
    for (int b = 63; b >= 0; b--) begin
      t = len | (64'd1 << b);
      t2 = 128'(t) * 128'(t);
      if (t2 <= sq) len = t;
    end
    r = '0;
    if (len == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      mag = c[i] < 0 ? -c[i] : c[i];
      q = (mag << OFB) / len;
      if (c[i] < 0) q = -q;
      o[i] = q[OW-1:0];
    end
    r.ux = o[0];
    r.uy = o[1];
    r.uz = o[2];
    return r;
  endfunction

  class normal_scoreboard;
    rsp_t pending_normals[$];

    function void note_request(req_t v);
      pending_normals.push_back(unit_normal(v));
    endfunction

    task check_result(rsp_t got);
      rsp_t want;
      if (pending_normals.size() == 0) begin
        report_mismatch("unexpected result", got, 0);
        return;
      end
      want = pending_normals.pop_front();
      if (got.ux !== want.ux) report_mismatch("ux", got.ux, want.ux);
      if (got.uy !== want.uy) report_mismatch("uy", got.uy, want.uy);
      if (got.uz !== want.uz) report_mismatch("uz", got.uz, want.uz);
      if (got.degenerate !== want.degenerate)
        report_mismatch("degenerate", got.degenerate, want.degenerate);
    endtask
  endclass

  normal_scoreboard scb = new();

  // Mostly short gaps, a few long ones, some stretches with none
  function automatic int gap_len(input int mode);
    int p;
    p = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [CW-1:0] rand_comp();
    int p;
    p = $urandom_range(0, 9);
    case (p)
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return $urandom_range(0, 1) ? 16'sh0001 : 16'shffff;
      3: return 16'sh0000;
      4: return CW'($signed($urandom_range(0, 1023)) - 512);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic req_t rand_request();
    req_t v;
    int   k;
    v.ax = rand_comp(); v.ay = rand_comp(); v.az = rand_comp();
    v.bx = rand_comp(); v.by = rand_comp(); v.bz = rand_comp();
    // Make b a multiple of a now and then to hit parallel pairs
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(0, 1) ? -2 : 3;
      v.ax = CW'($signed($urandom_range(0, 4000)) - 2000);
      v.ay = CW'($signed($urandom_range(0, 4000)) - 2000);
      v.az = CW'($signed($urandom_range(0, 4000)) - 2000);
      v.bx = CW'(v.ax * k); v.by = CW'(v.ay * k); v.bz = CW'(v.az * k);
    end
    return v;
  endfunction

  // Drop valid over the idle gap, then hold the request until it is taken
  task automatic send_request(input req_t v, input int mode);
    int g;
    g = gap_len(mode);
    if (g > 0) begin
      src_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data  <= v;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    scb.note_request(v);
  endtask

  function automatic req_t make_req(input int a0, a1, a2, b0, b1, b2);
    req_t v;
    v.ax = CW'(a0); v.ay = CW'(a1); v.az = CW'(a2);
    v.bx = CW'(b0); v.by = CW'(b1); v.bz = CW'(b2);
    return v;
  endfunction

  // Stimulus
  initial begin
    req_t directed [$];
    int   mode;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    directed.push_back(make_req(0, 0, 0, 0, 0, 0));
    directed.push_back(make_req(256, 0, 0, 0, 256, 0));
    directed.push_back(make_req(0, 256, 0, 256, 0, 0));
    directed.push_back(make_req(0, 0, 256, 256, 0, 0));
    directed.push_back(make_req(256, 0, 0, 0, 0, -256));
    directed.push_back(make_req(300, 400, 500, 600, 800, 1000));
    directed.push_back(make_req(1, 2, 3, 0, 0, 0));
    directed.push_back(make_req(32767, 32767, 32767, -32768, -32768, -32768));
    directed.push_back(make_req(-32768, 0, 0, 0, -32768, 0));
    directed.push_back(make_req(-32768, -32768, -32768, 32767, -32768, 32767));
    directed.push_back(make_req(32767, -32768, 32767, -32768, 32767, -32768));
    directed.push_back(make_req(32767, 0, -32768, 0, 32767, 0));
    directed.push_back(make_req(1, 0, 0, 0, 1, 0));
    directed.push_back(make_req(-1, -1, -1, 1, -1, 1));
    directed.push_back(make_req(-21846, 21845, -1, 1, -21846, 21845));
    directed.push_back(make_req(256, 256, 0, 256, -256, 0));
    directed.push_back(make_req(5, -7, 11, -13, 17, -19));
    directed.push_back(make_req(-32768, -32768, 0, -32768, -32768, 0));
    foreach (directed[i]) send_request(directed[i], 1);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      mode = (n / 200) % 3;
      send_request(rand_request(), mode);
    end
    src_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stall pattern
  initial begin
    int g;
    int phase;
    @(negedge rst);
    forever begin
      phase = $urandom_range(0, 3);
      if (phase == 0) begin
        dst_stall <= 1'b0;
        repeat ($urandom_range(20, 150)) @(posedge clk);
      end else begin
        g = gap_len(1);
        dst_stall <= (g > 0);
        repeat (g > 0 ? g : 1) @(posedge clk);
        dst_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  // Check accepted results
  always @(posedge clk) begin
    if (!rst && dst_valid && !dst_stall) scb.check_result(dst_data);
  end

  // Drain and finish
  initial begin
    wait (stim_done);
    while (scb.pending_normals.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0 && scb.pending_normals.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ncp_pkg.sv
rtl/core/ncp_front.sv
rtl/core/ncp_sqrt_cell.sv
rtl/core/ncp_div_cell.sv
rtl/core/normalized_cross_product_core.sv
dv/tb_normalized_cross_product_core.sv
